// ===== rtl/switch_matrix_release_debounce_assert.svh =====
// Assertion macros shared by the switch matrix debounce checker.
// No dependencies; included by name where assertions are written.
`ifndef SWITCH_MATRIX_RELEASE_DEBOUNCE_ASSERT_SVH
`define SWITCH_MATRIX_RELEASE_DEBOUNCE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define SMRD_AST_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("smrd assertion failed");

// next-cycle implication, disabled during reset
`define SMRD_AST_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("smrd assertion failed");

`endif

// ===== rtl/smrd_pkg.sv =====
// Shared constants and types for the switch matrix debounce block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package smrd_pkg;

    localparam int NUM_ROWS  = 8;
    localparam int NUM_COLS  = 8;
    localparam int TIME_BITS = 32;
    localparam int ROW_BITS  = 3;
    localparam int COL_BITS  = 3;
    localparam int DEB_BITS  = 16;

    localparam logic [DEB_BITS-1:0] DEB_RESET = DEB_BITS'(20);

    typedef logic [NUM_COLS-1:0]  t_row_bits;
    typedef logic [ROW_BITS-1:0]  t_row_idx;
    typedef logic [COL_BITS-1:0]  t_col_idx;
    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [DEB_BITS-1:0]  t_deb;
    typedef t_time [NUM_COLS-1:0] t_stamp_row;

    // outcome of evaluating one scanned row
    typedef struct packed {
        t_row_bits changed;     // accepted latch changes
        t_row_bits latch_next;  // row latch after update
        t_row_bits wr_en;       // stamps to rewrite with the scan time
        logic      any_diff;    // raw level differed from latch somewhere
        t_col_idx  last_col;    // highest differing column
        logic      last_level;  // raw level at that column
    } t_eval_res;

endpackage

// ===== rtl/smrd_stamp_ram.sv =====
// Per-switch timestamp memory: one row of stamps per word, column write enables.
// Depends on smrd_pkg. Read data is registered.
`timescale 1ns / 1ps

module smrd_stamp_ram (
    input  logic                 i_clk,
    input  smrd_pkg::t_row_bits  i_wr_en,
    input  smrd_pkg::t_row_idx   i_wr_row,
    input  smrd_pkg::t_time      i_wr_time,
    input  logic                 i_rd_en,
    input  smrd_pkg::t_row_idx   i_rd_row,
    output smrd_pkg::t_stamp_row o_rd_data
);
    import smrd_pkg::*;

    t_stamp_row r_mem [NUM_ROWS];
    t_stamp_row r_rd_data;

    always_ff @(posedge i_clk) begin
        for (int c = 0; c < NUM_COLS; c++) begin
            if (i_wr_en[c]) begin
                r_mem[i_wr_row][c] <= i_wr_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_row];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/smrd_col_eval.sv =====
// Column checks for one scanned row: close at once, open after debounce time.
// Depends on smrd_pkg. Purely combinational.
`timescale 1ns / 1ps

module smrd_col_eval (
    input  smrd_pkg::t_row_bits  i_latch,
    input  smrd_pkg::t_row_bits  i_raw,
    input  smrd_pkg::t_time      i_now,
    input  smrd_pkg::t_stamp_row i_stamps,
    input  smrd_pkg::t_deb       i_debounce,
    output smrd_pkg::t_eval_res  o_res
);
    import smrd_pkg::*;

    t_row_bits diff;
    t_time     elapsed [NUM_COLS];
    t_time     deb_ext;
    t_eval_res res;

    assign diff    = i_latch ^ i_raw;
    assign deb_ext = {{(TIME_BITS - DEB_BITS){1'b0}}, i_debounce};

    always_comb begin
        res            = '0;
        res.latch_next = i_latch;
        res.any_diff   = |diff;
        for (int c = 0; c < NUM_COLS; c++) begin
            elapsed[c] = i_now - i_stamps[c];   // wraps modulo 2^TIME_BITS
            if (diff[c]) begin
                res.last_col   = COL_BITS'(c);  // highest column wins
                res.last_level = i_raw[c];
                if (i_raw[c]) begin
                    res.latch_next[c] = 1'b1;
                    res.wr_en[c]      = 1'b1;
                    res.changed[c]    = 1'b1;
                end else if (elapsed[c] >= deb_ext) begin
                    res.latch_next[c] = 1'b0;
                    res.wr_en[c]      = 1'b1;
                    res.changed[c]    = 1'b1;
                end
            end
        end
    end

    assign o_res = res;

endmodule

// ===== rtl/switch_matrix_release_debounce.sv =====
// An accepted word is held in the scan stage, then moves into the result register.
// Throughput: one word per cycle unless the result register stalls; the stamp
// memory is read on accept, written on retire, with a one-deep same-row bypass.
// Reset (synchronous, active low) zeroes latches, stamp valid bits, the
// last-change record and the pipeline; debounce returns to 20 ms.
// Depends on smrd_pkg, smrd_stamp_ram and smrd_col_eval.
`timescale 1ns / 1ps

module switch_matrix_release_debounce (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration: debounce time in ms
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  smrd_pkg::t_deb      i_cfg_data,
    // scan input
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [2:0]          i_row_index,
    input  logic [7:0]          i_return_bits,
    input  logic [31:0]         i_time_ms,
    // scan result
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_changed_bits,
    output logic [7:0]          o_row_state,
    output logic [2:0]          o_last_col,
    output logic [2:0]          o_last_row,
    output logic                o_last_closed,
    output logic                o_last_valid
);
    import smrd_pkg::*;

    // configuration
    t_deb       r_debounce;

    // debounced latches and per-switch stamp valid bits
    t_row_bits  r_latch     [NUM_ROWS];
    t_row_bits  r_stamp_vld [NUM_ROWS];

    // scan stage: input word plus bypass of the previous stamp write
    logic       r_s1_valid;
    t_row_idx   r_s1_row;
    t_row_bits  r_s1_raw;
    t_time      r_s1_time;
    t_row_bits  r_fwd_en;
    t_time      r_fwd_time;

    // record of the last raw difference
    t_col_idx   r_last_col;
    t_row_idx   r_last_row;
    logic       r_last_closed;
    logic       r_last_seen;

    // result register
    logic       r_out_valid;
    t_row_bits  r_out_changed;
    t_row_bits  r_out_state;
    t_col_idx   r_out_last_col;
    t_row_idx   r_out_last_row;
    logic       r_out_last_closed;
    logic       r_out_last_seen;

    logic       s1_fire;
    logic       in_acc;
    t_row_bits  n_fwd_en;
    t_row_bits  ram_wr_en;
    t_stamp_row rd_stamps;
    t_stamp_row eff_stamps;
    t_row_bits  cur_latch;
    t_row_bits  cur_vld;
    t_eval_res  ev;
    t_col_idx   n_last_col;
    t_row_idx   n_last_row;
    logic       n_last_closed;
    logic       n_last_seen;

    // handshakes: the scan stage retires when the result slot is free or draining
    assign s1_fire     = r_s1_valid && (!r_out_valid || i_ready);
    assign o_ready     = !r_s1_valid || s1_fire;
    assign in_acc      = i_valid && o_ready;
    assign o_cfg_ready = 1'b1;

    // stamps written this cycle are missed by a same-row read issued now
    assign n_fwd_en  = (s1_fire && (i_row_index == r_s1_row)) ? ev.wr_en : '0;
    assign ram_wr_en = s1_fire ? ev.wr_en : '0;

    smrd_stamp_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_row  (r_s1_row),
        .i_wr_time (r_s1_time),
        .i_rd_en   (in_acc),
        .i_rd_row  (i_row_index),
        .o_rd_data (rd_stamps)
    );

    assign cur_latch = r_latch[r_s1_row];
    assign cur_vld   = r_stamp_vld[r_s1_row];

    // bypass first, then never-written stamps read as zero
    always_comb begin
        for (int c = 0; c < NUM_COLS; c++) begin
            if (r_fwd_en[c]) begin
                eff_stamps[c] = r_fwd_time;
            end else if (cur_vld[c]) begin
                eff_stamps[c] = rd_stamps[c];
            end else begin
                eff_stamps[c] = '0;
            end
        end
    end

    smrd_col_eval u_eval (
        .i_latch    (cur_latch),
        .i_raw      (r_s1_raw),
        .i_now      (r_s1_time),
        .i_stamps   (eff_stamps),
        .i_debounce (r_debounce),
        .o_res      (ev)
    );

    // last-change record moves only on a scan with a raw difference
    always_comb begin
        n_last_col    = r_last_col;
        n_last_row    = r_last_row;
        n_last_closed = r_last_closed;
        n_last_seen   = r_last_seen;
        if (ev.any_diff) begin
            n_last_col    = ev.last_col;
            n_last_row    = r_s1_row;
            n_last_closed = ev.last_level;
            n_last_seen   = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEB_RESET;
        end else if (i_cfg_valid) begin
            r_debounce <= i_cfg_data;
        end
    end

    // scan stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_fwd_en   <= '0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
                r_fwd_en   <= n_fwd_en;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_row   <= i_row_index;
            r_s1_raw   <= i_return_bits;
            r_s1_time  <= i_time_ms;
            r_fwd_time <= r_s1_time;
        end
    end

    // matrix state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                r_latch[r]     <= '0;
                r_stamp_vld[r] <= '0;
            end
            r_last_col    <= '0;
            r_last_row    <= '0;
            r_last_closed <= 1'b0;
            r_last_seen   <= 1'b0;
        end else if (s1_fire) begin
            r_latch[r_s1_row]     <= ev.latch_next;
            r_stamp_vld[r_s1_row] <= cur_vld | ev.wr_en;
            r_last_col            <= n_last_col;
            r_last_row            <= n_last_row;
            r_last_closed         <= n_last_closed;
            r_last_seen           <= n_last_seen;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid       <= 1'b0;
            r_out_changed     <= '0;
            r_out_state       <= '0;
            r_out_last_col    <= '0;
            r_out_last_row    <= '0;
            r_out_last_closed <= 1'b0;
            r_out_last_seen   <= 1'b0;
        end else if (s1_fire) begin
            r_out_valid       <= 1'b1;
            r_out_changed     <= ev.changed;
            r_out_state       <= ev.latch_next;
            r_out_last_col    <= n_last_col;
            r_out_last_row    <= n_last_row;
            r_out_last_closed <= n_last_closed;
            r_out_last_seen   <= n_last_seen;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_changed_bits = r_out_changed;
    assign o_row_state    = r_out_state;
    assign o_last_col     = r_out_last_col;
    assign o_last_row     = r_out_last_row;
    assign o_last_closed  = r_out_last_closed;
    assign o_last_valid   = r_out_last_seen;

endmodule

// ===== rtl/smrd_checker.sv =====
// Port-level checker for the switch matrix debounce block, bound to the top.
// Depends on smrd_pkg and switch_matrix_release_debounce_assert.svh.
`timescale 1ns / 1ps
`include "switch_matrix_release_debounce_assert.svh"

module smrd_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_valid,
    input logic                i_ready,
    input smrd_pkg::t_row_bits o_changed_bits,
    input smrd_pkg::t_row_bits o_row_state,
    input smrd_pkg::t_col_idx  o_last_col,
    input smrd_pkg::t_row_idx  o_last_row,
    input logic                o_last_closed,
    input logic                o_last_valid
);
    import smrd_pkg::*;

    // stalled result holds its word
    `SMRD_AST_NXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid && $stable(o_changed_bits) && $stable(o_row_state))
    // an accepted change implies a raw difference was recorded
    `SMRD_AST_NOW(a_change_seen, i_clk, i_rst_n, o_valid && (o_changed_bits != '0), o_last_valid)
    // no record yet means the record fields are still clear
    `SMRD_AST_NOW(a_record_clear, i_clk, i_rst_n, o_valid && !o_last_valid, (o_last_col == '0) && (o_last_row == '0) && !o_last_closed)
    // once a difference is seen it is never forgotten
    `SMRD_AST_NXT(a_record_sticky, i_clk, i_rst_n, o_last_valid, o_last_valid)

endmodule

bind switch_matrix_release_debounce smrd_checker u_smrd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_changed_bits (o_changed_bits),
    .o_row_state    (o_row_state),
    .o_last_col     (o_last_col),
    .o_last_row     (o_last_row),
    .o_last_closed  (o_last_closed),
    .o_last_valid   (o_last_valid)
);

// ===== sim/switch_matrix_release_debounce_tb.sv =====
// Self-checking testbench for switch_matrix_release_debounce: a directed table,
// then random row scans checked against a behavioral model of the debouncer.
// Depends on smrd_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module switch_matrix_release_debounce_tb;

    import smrd_pkg::*;

    // run limits
    localparam int unsigned CYCLE_LIMIT  = 600000;  // many times the slowest legal run
    localparam int unsigned PHASES       = 6;
    localparam int unsigned PHASE_SCANS  = 258;     // about 1550 random words in total
    localparam int unsigned HOLD_CYCLES  = 500;     // long receiver stall
    localparam int unsigned MAX_GAP      = 18;
    localparam int unsigned SETTLE       = 4;       // pipeline is two stages deep
    localparam int unsigned REPORT_MAX   = 10;

    // idle styles of either side
    localparam int unsigned GAP_NONE     = 0;
    localparam int unsigned GAP_UNIFORM  = 1;
    localparam int unsigned GAP_BURSTY   = 2;

    // one result word as the block presents it
    typedef struct packed {
        t_row_bits changed;
        t_row_bits state;
        t_col_idx  col;
        t_row_idx  row;
        logic      closed;
        logic      seen;
    } scan_res_t;

    typedef enum logic [0:0] {STEP_SCAN, STEP_CFG} step_kind_e;

    // directed step: a scan word, or a debounce write between phases
    typedef struct packed {
        step_kind_e kind;
        t_deb       deb;
        t_row_idx   row;
        t_row_bits  bits;
        t_time      tm;
        logic       pinned;   // res holds a hand-computed result
        scan_res_t  res;
    } dir_step_t;

    localparam int unsigned DIR_STEPS = 21;

    dir_step_t dir_tbl [DIR_STEPS] = '{
        // after reset: no difference, nothing seen yet
        '{STEP_SCAN, 16'd0,     3'd0, 8'h00, 32'h0000_0000, 1'b1,
          '{8'h00, 8'h00, 3'd0, 3'd0, 1'b0, 1'b0}},
        // every switch of the top row closes at the top of the time range
        '{STEP_SCAN, 16'd0,     3'd7, 8'hFF, 32'hFFFF_FFFF, 1'b1,
          '{8'hFF, 8'hFF, 3'd7, 3'd7, 1'b1, 1'b1}},
        // release 6 ms later across the wrap: too early, suppressed
        '{STEP_SCAN, 16'd0,     3'd7, 8'h00, 32'h0000_0005, 1'b0, '0},
        // exactly 20 ms after the stamp: accepted
        '{STEP_SCAN, 16'd0,     3'd7, 8'h00, 32'h0000_0013, 1'b0, '0},
        // no raw difference, last-change record repeats
        '{STEP_SCAN, 16'd0,     3'd7, 8'h00, 32'h0000_0064, 1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd3, 8'h01, 32'd1000,      1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd3, 8'h00, 32'd1019,      1'b0, '0},
        // one release on time plus one close in the same scan
        '{STEP_SCAN, 16'd0,     3'd3, 8'h80, 32'd1020,      1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd3, 8'h55, 32'd2000,      1'b0, '0},
        // closes taken, early releases dropped
        '{STEP_SCAN, 16'd0,     3'd3, 8'hAA, 32'd2005,      1'b0, '0},
        // zero debounce: releases go through at once
        '{STEP_CFG,  16'd0,     3'd0, 8'h00, 32'd0,         1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd3, 8'h00, 32'd2005,      1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd0, 8'h0F, 32'd2005,      1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd0, 8'hF0, 32'd2005,      1'b0, '0},
        // longest debounce: one short of it, then exactly it
        '{STEP_CFG,  16'hFFFF,  3'd0, 8'h00, 32'd0,         1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd1, 8'hFF, 32'h8000_0000, 1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd1, 8'h00, 32'h8000_FFFE, 1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd1, 8'h00, 32'h8000_FFFF, 1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd5, 8'h3C, 32'h7FFF_FFFF, 1'b0, '0},
        '{STEP_CFG,  16'd20,    3'd0, 8'h00, 32'd0,         1'b0, '0},
        '{STEP_SCAN, 16'd0,     3'd6, 8'hC3, 32'h1234_5678, 1'b0, '0}
    };

    // block ports
    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    t_deb       i_cfg_data;
    logic       i_valid;
    logic       o_ready;
    logic [2:0] i_row_index;
    logic [7:0] i_return_bits;
    logic [31:0] i_time_ms;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_changed_bits;
    logic [7:0] o_row_state;
    logic [2:0] o_last_col;
    logic [2:0] o_last_row;
    logic       o_last_closed;
    logic       o_last_valid;

    switch_matrix_release_debounce u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_row_index    (i_row_index),
        .i_return_bits  (i_return_bits),
        .i_time_ms      (i_time_ms),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_changed_bits (o_changed_bits),
        .o_row_state    (o_row_state),
        .o_last_col     (o_last_col),
        .o_last_row     (o_last_row),
        .o_last_closed  (o_last_closed),
        .o_last_valid   (o_last_valid)
    );

    // debouncer image, advanced on every accepted word
    t_row_bits latch_img [NUM_ROWS];
    t_time     stamp_img [NUM_ROWS][NUM_COLS];
    t_col_idx  chg_col;
    t_row_idx  chg_row;
    logic      chg_level;
    logic      chg_seen;
    t_deb      deb_img;

    scan_res_t   pending_scans [$];   // results still owed by the block
    int unsigned scans_sent;
    int unsigned scans_seen;
    int unsigned mismatch_cnt;
    int unsigned cyc;

    // hand-computed result riding along with the word being offered
    logic      drv_pinned;
    scan_res_t drv_pin_res;

    // idle control
    int unsigned tx_mode;
    int unsigned rx_mode;
    int unsigned rx_gap;
    logic        hold_go;
    logic        hold_rx;

    // stimulus-side view of the switches
    t_row_bits raw_img [NUM_ROWS];
    t_time     tnow;
    t_deb      deb_now;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic int unsigned gap_draw(input int unsigned mode);
        if (mode == GAP_NONE)
            return 0;
        if (mode == GAP_BURSTY && $urandom_range(0, 7) != 0)
            return 0;
        return $urandom_range(0, MAX_GAP);
    endfunction

    // one row scan: closes latch and stamp at once, releases only once the
    // debounce time has run out since the stamp (wrapping difference)
    function automatic scan_res_t scan_update(input t_row_idx r, input t_row_bits raw,
                                              input t_time now);
        t_row_bits latch;
        t_row_bits diff;
        scan_res_t res;
        int c;
        latch = latch_img[r];
        diff  = latch ^ raw;
        for (c = 0; c < NUM_COLS; c++) begin
            if (diff[c]) begin
                // highest differing column wins the last-change record
                chg_col   = t_col_idx'(c);
                chg_row   = r;
                chg_level = raw[c];
                chg_seen  = 1'b1;
                if (raw[c]) begin
                    latch[c]        = 1'b1;
                    stamp_img[r][c] = now;
                end else if (t_time'(now - stamp_img[r][c]) >= t_time'(deb_img)) begin
                    latch[c]        = 1'b0;
                    stamp_img[r][c] = now;
                end else begin
                    diff[c] = 1'b0;   // bounce: release suppressed
                end
            end
        end
        latch_img[r] = latch;
        res.changed = diff;
        res.state   = latch;
        res.col     = chg_col;
        res.row     = chg_row;
        res.closed  = chg_level;
        res.seen    = chg_seen;
        return res;
    endfunction

    // input side: track config writes and predict each accepted scan word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NUM_ROWS; r++) begin
                latch_img[r] = '0;
                for (int c = 0; c < NUM_COLS; c++)
                    stamp_img[r][c] = '0;
            end
            chg_col   = '0;
            chg_row   = '0;
            chg_level = 1'b0;
            chg_seen  = 1'b0;
            deb_img   = DEB_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready)
                deb_img = i_cfg_data;
            if (i_valid && o_ready) begin
                scan_res_t want;
                want = scan_update(i_row_index, i_return_bits, i_time_ms);
                // a hand-computed row stands in for the prediction
                pending_scans.push_back(drv_pinned ? drv_pin_res : want);
            end
        end
    end

    // output side: compare each result word with the oldest one owed
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            scan_res_t got;
            scan_res_t want;
            got = '{o_changed_bits, o_row_state, o_last_col, o_last_row,
                    o_last_closed, o_last_valid};
            if (pending_scans.size() == 0) begin
                mismatch_cnt++;
                if (mismatch_cnt <= REPORT_MAX)
                    $display("unexpected result word: chg=%h st=%h col=%0d row=%0d cl=%b v=%b",
                             got.changed, got.state, got.col, got.row, got.closed, got.seen);
            end else begin
                want = pending_scans.pop_front();
                if (got.changed !== want.changed || got.state !== want.state ||
                    got.col !== want.col || got.row !== want.row ||
                    got.closed !== want.closed || got.seen !== want.seen) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX)
                        $display("scan %0d mismatch: exp chg=%h st=%h col=%0d row=%0d cl=%b v=%b, got chg=%h st=%h col=%0d row=%0d cl=%b v=%b",
                                 scans_seen, want.changed, want.state, want.col, want.row,
                                 want.closed, want.seen, got.changed, got.state, got.col,
                                 got.row, got.closed, got.seen);
                end
            end
            scans_seen++;
        end
    end

    // receiver: one ready decision per edge, so ready is never dropped and
    // raised in the same step; hold_rx forces a long stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_gap  <= 0;
        end else if (i_ready) begin
            if (o_valid) begin
                int unsigned g;
                g = gap_draw(rx_mode);
                if (g != 0 || hold_rx)
                    i_ready <= 1'b0;
                rx_gap <= g;
            end
        end else if (rx_gap != 0) begin
            rx_gap <= rx_gap - 1;
        end else if (!hold_rx) begin
            i_ready <= 1'b1;
        end
    end

    // long receiver stall, counted here so the sender keeps pushing words
    initial begin
        hold_rx = 1'b0;
        wait (hold_go);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // offer one scan word, leaving valid high after the handshake so the
    // next word can follow without a bubble
    task automatic send_scan(input t_row_idx r, input t_row_bits b, input t_time t,
                             input logic pin, input scan_res_t pin_res);
        int unsigned gap;
        gap = gap_draw(tx_mode);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_row_index   <= r;
        i_return_bits <= b;
        i_time_ms     <= t;
        drv_pinned    <= pin;
        drv_pin_res   <= pin_res;
        do @(posedge i_clk); while (!o_ready);
        scans_sent++;
    endtask

    // debounce write with the block idle: all owed results in, pipe drained
    task automatic write_debounce(input t_deb v);
        i_valid <= 1'b0;
        while (scans_seen != scans_sent) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        deb_now = v;
    endtask

    // random scan: mostly a switch or two bouncing against the last raw
    // levels, some wide changes, repeats and plain noise; time mostly creeps
    // forward in steps scaled to the debounce, sometimes jumps anywhere
    task automatic random_scan();
        t_row_idx  r;
        t_row_bits b;
        int unsigned pick;
        r    = t_row_idx'($urandom_range(0, NUM_ROWS - 1));
        pick = $urandom_range(0, 99);
        if (pick < 60)
            b = raw_img[r] ^ t_row_bits'(1 << $urandom_range(0, NUM_COLS - 1))
                           ^ (($urandom_range(0, 3) == 0) ?
                              t_row_bits'(1 << $urandom_range(0, NUM_COLS - 1)) : '0);
        else if (pick < 80)
            b = raw_img[r] ^ t_row_bits'($urandom_range(0, 255));
        else if (pick < 90)
            b = raw_img[r];
        else
            b = t_row_bits'($urandom_range(0, 255));
        raw_img[r] = b;
        tnow = tnow + t_time'($urandom_range(0, deb_now / 4 + 3));
        if ($urandom_range(0, 49) == 0)
            tnow = t_time'($urandom());
        send_scan(r, b, tnow, 1'b0, '0);
    endtask

    initial begin
        // every input known from time zero
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_data    = '0;
        i_valid       = 1'b0;
        i_row_index   = '0;
        i_return_bits = '0;
        i_time_ms     = '0;
        drv_pinned    = 1'b0;
        drv_pin_res   = '0;
        hold_go       = 1'b0;
        scans_sent    = 0;
        scans_seen    = 0;
        mismatch_cnt  = 0;
        cyc           = 0;
        tx_mode       = GAP_UNIFORM;
        rx_mode       = GAP_UNIFORM;
        deb_now       = DEB_RESET;
        tnow          = '0;
        for (int r = 0; r < NUM_ROWS; r++)
            raw_img[r] = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        for (int k = 0; k < DIR_STEPS; k++) begin
            if (dir_tbl[k].kind == STEP_CFG)
                write_debounce(dir_tbl[k].deb);
            else
                send_scan(dir_tbl[k].row, dir_tbl[k].bits, dir_tbl[k].tm,
                          dir_tbl[k].pinned, dir_tbl[k].res);
        end

        // raw image follows the rows the table left behind
        raw_img[0] = 8'hF0;
        raw_img[1] = 8'h00;
        raw_img[3] = 8'h00;
        raw_img[5] = 8'h3C;
        raw_img[6] = 8'hC3;
        raw_img[7] = 8'h00;
        tnow       = 32'h1234_5678;

        // random phases, each under its own debounce setting and idle style
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    write_debounce(t_deb'($urandom_range(1, 40)));
                end
                1: begin
                    // back-to-back words into a stalled receiver
                    write_debounce(t_deb'(0));
                    tx_mode = GAP_NONE;
                    rx_mode = GAP_BURSTY;
                    hold_go = 1'b1;
                end
                2: begin
                    write_debounce(16'hFFFF);
                    tnow    = 32'hFFFF_0000;
                    tx_mode = GAP_UNIFORM;
                    rx_mode = GAP_NONE;
                end
                3: begin
                    write_debounce(t_deb'($urandom_range(0, 65535)));
                    tx_mode = GAP_BURSTY;
                    rx_mode = GAP_UNIFORM;
                end
                4: begin
                    write_debounce(DEB_RESET);
                    tx_mode = GAP_NONE;
                    rx_mode = GAP_NONE;
                end
                default: begin
                    write_debounce(t_deb'($urandom_range(1, 200)));
                    tx_mode = GAP_UNIFORM;
                    rx_mode = GAP_BURSTY;
                end
            endcase
            repeat (PHASE_SCANS) random_scan();
        end

        // drain and settle
        i_valid <= 1'b0;
        while (scans_seen != scans_sent) @(posedge i_clk);
        repeat (2 * SETTLE) @(posedge i_clk);
        if (pending_scans.size() != 0)
            mismatch_cnt++;

        if (mismatch_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
